// ===== rtl/bpa_pkg.sv =====
// Shared constants, result codes and controller/datapath interface types of the page allocator.
package bpa_pkg;

    localparam int PAGE_COUNT_DEF = 2048;

    localparam int WORD_W     = 32;
    localparam int IW         = $clog2(WORD_W);
    localparam int PAGE_SHIFT = 12;
    localparam int SIZE_W     = 32;
    localparam int ADDR_W     = 32;
    localparam int OUT_ADDR_W = 23;
    localparam int CNT_W      = 12;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_PAD_W  = OUT_DATA_W - STATUS_W - OUT_ADDR_W - CNT_W;

    localparam logic [CNT_W-1:0] CNT_MAX      = '1;
    localparam logic [CNT_W-1:0] RESERVED_RST = 12'd512;
    localparam logic [CNT_W-1:0] INIT_FREE_RST = 12'd1536;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTUSED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_FREE = 2'd1;

    typedef struct packed {
        logic                init_row;
        logic                load;
        logic                scan_init;
        logic                scan_step;
        logic                walk_init;
        logic                walk_rd;
        logic                mark_wr;
        logic                free_wr;
        logic                finish;
        logic [STATUS_W-1:0] res_status;
    } cmd_t;

    typedef struct packed {
        logic row_last;
        logic func_free;
        logic n_zero;
        logic alloc_nofit;
        logic free_bad;
        logic scan_found;
        logic scan_done;
        logic walk_last;
        logic free_err;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/bitmap_page_allocator.sv =====
// Top level of the first-fit bitmap page allocator.
//
//  Channel   Direction  Handshake                    Contents
//  s_axis    in         s_axis_tvalid/s_axis_tready  allocate or free request
//  m_axis    out        m_axis_tvalid/m_axis_tready  status, run address, free count
//  cfg       in         cfg_valid/cfg_ready          register index and value
//
// An allocate scans map words from the boundary word up to the word where the run
// completes, then reads and writes back each word of the run to mark it.
// A free reads, then writes, each map word of its range.
// The map RAM has one read and one write port; each word is 32 pages.
// After reset and after every register write a clearing pass rebuilds the map, and no
// request is taken meanwhile.
// One request is handled at a time; a finished result waits in the output register.
module bitmap_page_allocator
    import bpa_pkg::*;
#(
    parameter int PAGE_COUNT = PAGE_COUNT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // size_bytes[31:0], base_address[63:32]
    input  logic [0:0]            s_axis_tuser,   // func[0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // status[1:0], page_address[24:2],
                                                  // free_pages[36:25], zero[39:37]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t                  cmd;
    status_t               st;
    logic                  cfg_we;
    logic [STATUS_W-1:0]   res_status;
    logic [OUT_ADDR_W-1:0] res_addr;
    logic [CNT_W-1:0]      res_free;

    assign cfg_ready = 1'b1;
    // Writes to indexes outside the register list are taken and dropped.
    assign cfg_we    = cfg_valid && cfg_ready &&
                       ((cfg_index == CFG_RESERVED) || (cfg_index == CFG_INIT_FREE));

    bpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .cfg_we   (cfg_we),
        .st       (st),
        .cmd      (cmd)
    );

    bpa_dp #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_func    (s_axis_tuser[0]),
        .in_size    (s_axis_tdata[SIZE_W-1:0]),
        .in_base    (s_axis_tdata[IN_DATA_W-1:SIZE_W]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (res_status),
        .out_addr   (res_addr),
        .out_free   (res_free)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res_free, res_addr, res_status};

endmodule

// ===== rtl/bpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bpa_ctrl.sv =====
// Sequencing state machine of the page allocator.
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    cfg_we,
    input  status_t st,
    output cmd_t    cmd
);

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_CHECK   = 4'd2;
    localparam logic [3:0] S_SCAN    = 4'd3;
    localparam logic [3:0] S_MARK_RD = 4'd4;
    localparam logic [3:0] S_MARK_WR = 4'd5;
    localparam logic [3:0] S_FREE_RD = 4'd6;
    localparam logic [3:0] S_FREE_WR = 4'd7;
    localparam logic [3:0] S_RESP    = 4'd8;

    logic [3:0]          state_reg, state_next;
    logic [STATUS_W-1:0] code_reg, code_next;

    assign in_ready = (state_reg == S_IDLE) && !cfg_we;

    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        cmd            = '0;
        cmd.res_status = code_reg;
        if (cfg_we)
        begin
            // Any register write rebuilds the map from scratch.
            state_next = S_INIT;
        end
        else
        begin
            unique case (state_reg)
                S_INIT:
                begin
                    cmd.init_row = 1'b1;
                    if (st.row_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (!st.func_free)
                    begin
                        if (st.n_zero)
                        begin
                            code_next  = ST_BAD;
                            state_next = S_RESP;
                        end
                        else if (st.alloc_nofit)
                        begin
                            code_next  = ST_NOSPACE;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (st.free_bad)
                        begin
                            code_next  = ST_BAD;
                            state_next = S_RESP;
                        end
                        else if (st.n_zero)
                        begin
                            code_next  = ST_OK;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            cmd.walk_init = 1'b1;
                            state_next    = S_FREE_RD;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (st.scan_found)
                    begin
                        cmd.walk_init = 1'b1;
                        state_next    = S_MARK_RD;
                    end
                    else if (st.scan_done)
                    begin
                        code_next  = ST_NOSPACE;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        cmd.scan_step = 1'b1;
                    end
                end
                S_MARK_RD:
                begin
                    cmd.walk_rd = 1'b1;
                    state_next  = S_MARK_WR;
                end
                S_MARK_WR:
                begin
                    cmd.mark_wr = 1'b1;
                    if (st.walk_last)
                    begin
                        code_next  = ST_OK;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_MARK_RD;
                    end
                end
                S_FREE_RD:
                begin
                    cmd.walk_rd = 1'b1;
                    state_next  = S_FREE_WR;
                end
                S_FREE_WR:
                begin
                    cmd.free_wr = 1'b1;
                    if (st.free_err)
                    begin
                        code_next  = ST_NOTUSED;
                        state_next = S_RESP;
                    end
                    else if (st.walk_last)
                    begin
                        code_next  = ST_OK;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_FREE_RD;
                    end
                end
                S_RESP:
                begin
                    if (st.out_free)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                default:
                begin
                    state_next = S_INIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            code_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

endmodule

// ===== rtl/bpa_dp.sv =====
// Datapath of the page allocator: usage map RAM, word scanner, range walker, count and result.
module bpa_dp
    import bpa_pkg::*;
#(
    parameter int PAGE_COUNT = PAGE_COUNT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output status_t               st,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_func,
    input  logic [SIZE_W-1:0]     in_size,
    input  logic [ADDR_W-1:0]     in_base,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   out_status,
    output logic [OUT_ADDR_W-1:0] out_addr,
    output logic [CNT_W-1:0]      out_free
);

    localparam int ROWS = PAGE_COUNT / WORD_W;
    localparam int AW   = $clog2(ROWS);
    localparam int PW   = AW + IW;
    localparam int RW   = PW + 1;
    localparam int CW   = ((PW > CNT_W) ? PW : CNT_W) + 1;
    localparam int N_W  = SIZE_W - PAGE_SHIFT + 1;
    localparam int SP_W = ADDR_W - PAGE_SHIFT;
    localparam int EW   = N_W + 1;
    localparam logic [AW-1:0] LAST_ROW = AW'(ROWS - 1);

    // Used bits of one map word for the state after reinitialization.
    function automatic logic [WORD_W-1:0] row_init(input logic [AW-1:0] w,
                                                   input logic [CNT_W-1:0] rsv);
        logic [CW-1:0]     base;
        logic [CW-1:0]     r;
        logic [WORD_W-1:0] pat;
        base = CW'({w, IW'(0)});
        r    = CW'(rsv);
        if (r >= base + CW'(WORD_W))
        begin
            pat = '1;
        end
        else if (r <= base)
        begin
            pat = '0;
        end
        else
        begin
            pat = ~({WORD_W{1'b1}} << IW'(r - base));
        end
        return pat;
    endfunction

    logic [CNT_W-1:0]  reserved_reg, reserved_next;
    logic [CNT_W-1:0]  init_free_reg, init_free_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [AW-1:0]     row_reg, row_next;
    logic              func_reg, func_next;
    logic              n_zero_reg, n_zero_next;
    logic              nofit_reg, nofit_next;
    logic              free_bad_reg, free_bad_next;
    logic [RW-1:0]     n_reg, n_next;
    logic [PW-1:0]     lo_page_reg, lo_page_next;
    logic [PW-1:0]     hi_page_reg, hi_page_next;
    logic [AW-1:0]     scan_addr_reg, scan_addr_next;
    logic [AW-1:0]     eval_addr_reg, eval_addr_next;
    logic              scan_more_reg, scan_more_next;
    logic              eval_vld_reg, eval_vld_next;
    logic              found_reg, found_next;
    logic [RW-1:0]     carry_reg, carry_next;
    logic [AW-1:0]     walk_addr_reg, walk_addr_next;
    logic              out_vld_reg, out_vld_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [OUT_ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic [CNT_W-1:0]      out_free_reg, out_free_next;

    logic [WORD_W-1:0] rd_data;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;

    // Request decode.
    logic [N_W-1:0]  n_full;
    logic [SP_W-1:0] sp_full;
    logic [EW-1:0]   end_sum;

    assign n_full  = N_W'(in_size[SIZE_W-1:PAGE_SHIFT]) + N_W'(|in_size[PAGE_SHIFT-1:0]);
    assign sp_full = in_base[ADDR_W-1:PAGE_SHIFT];
    assign end_sum = EW'(sp_full) + EW'(n_full);

    // Word scanner: run length at every bit of the word under evaluation.
    logic [WORD_W-1:0] eval_word;
    logic [RW:0]       run_v [WORD_W];
    logic [WORD_W-1:0] hit_v;
    logic [IW-1:0]     hit_idx;
    logic              hit_now;
    logic              issue;
    logic [PW-1:0]     end_page;
    logic [PW-1:0]     start_page;

    // Pages below the boundary are never candidates, whatever the map says.
    assign eval_word = rd_data | row_init(eval_addr_reg, reserved_reg);

    always_comb
    begin
        for (int j = 0; j < WORD_W; j++)
        begin
            run_v[j] = (RW+1)'(carry_reg) + (RW+1)'(j + 1);
            for (int k = 0; k <= j; k++)
            begin
                if (eval_word[k])
                begin
                    run_v[j] = (RW+1)'(j - k);
                end
            end
            hit_v[j] = run_v[j] >= {1'b0, n_reg};
        end
    end

    always_comb
    begin
        hit_idx = '0;
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (hit_v[j])
            begin
                hit_idx = IW'(j);
            end
        end
    end

    assign hit_now    = eval_vld_reg && (|hit_v);
    assign issue      = scan_more_reg && !found_reg && !hit_now;
    assign end_page   = {eval_addr_reg, hit_idx};
    assign start_page = PW'({1'b0, end_page} + RW'(1) - n_reg);

    // Range walker: bits of the current word inside [lo_page, hi_page].
    logic [AW-1:0]     lo_row;
    logic [AW-1:0]     hi_row;
    logic [IW-1:0]     lo_b;
    logic [IW-1:0]     hi_b;
    logic [WORD_W-1:0] wmask;
    logic [WORD_W-1:0] miss;
    logic [IW-1:0]     miss_idx;
    logic [WORD_W-1:0] clr_mask;
    logic [IW:0]       freed;
    logic [CNT_W:0]    cnt_sum;

    assign lo_row = lo_page_reg[PW-1:IW];
    assign hi_row = hi_page_reg[PW-1:IW];
    assign lo_b   = (walk_addr_reg == lo_row) ? lo_page_reg[IW-1:0] : '0;
    assign hi_b   = (walk_addr_reg == hi_row) ? hi_page_reg[IW-1:0] : '1;
    assign wmask  = ({WORD_W{1'b1}} << lo_b) & ({WORD_W{1'b1}} >> (IW'(WORD_W - 1) - hi_b));
    assign miss   = wmask & ~rd_data;

    always_comb
    begin
        miss_idx = '0;
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (miss[j])
            begin
                miss_idx = IW'(j);
            end
        end
    end

    // On a page that is not in use, only the pages before it are released.
    assign clr_mask = (|miss) ? (wmask & ~({WORD_W{1'b1}} << miss_idx)) : wmask;
    assign freed    = (|miss) ? (IW+1)'(miss_idx - lo_b)
                              : (IW+1)'(hi_b) - (IW+1)'(lo_b) + (IW+1)'(1);
    assign cnt_sum  = (CNT_W+1)'(count_reg) + (CNT_W+1)'(freed);

    // Map RAM ports.
    assign ram_re    = (cmd.scan_step && issue) || cmd.walk_rd;
    assign ram_raddr = cmd.walk_rd ? walk_addr_reg : scan_addr_reg;
    assign ram_we    = cmd.init_row || cmd.mark_wr || cmd.free_wr;
    assign ram_waddr = cmd.init_row ? row_reg : walk_addr_reg;

    always_comb
    begin
        if (cmd.init_row)
        begin
            ram_wdata = row_init(row_reg, reserved_reg);
        end
        else if (cmd.mark_wr)
        begin
            ram_wdata = rd_data | wmask;
        end
        else
        begin
            ram_wdata = rd_data & ~clr_mask;
        end
    end

    bpa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    always_comb
    begin
        reserved_next   = reserved_reg;
        init_free_next  = init_free_reg;
        count_next      = count_reg;
        row_next        = row_reg;
        func_next       = func_reg;
        n_zero_next     = n_zero_reg;
        nofit_next      = nofit_reg;
        free_bad_next   = free_bad_reg;
        n_next          = n_reg;
        lo_page_next    = lo_page_reg;
        hi_page_next    = hi_page_reg;
        scan_addr_next  = scan_addr_reg;
        eval_addr_next  = eval_addr_reg;
        scan_more_next  = scan_more_reg;
        eval_vld_next   = eval_vld_reg;
        found_next      = found_reg;
        carry_next      = carry_reg;
        walk_addr_next  = walk_addr_reg;
        out_vld_next    = out_vld_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_free_next   = out_free_reg;

        if (cfg_we)
        begin
            if (cfg_index == CFG_RESERVED)
            begin
                reserved_next = cfg_data;
                count_next    = init_free_reg;
            end
            else
            begin
                init_free_next = cfg_data;
                count_next     = cfg_data;
            end
            row_next = '0;
        end

        if (cmd.init_row)
        begin
            row_next = (row_reg == LAST_ROW) ? '0 : row_reg + AW'(1);
        end

        if (cmd.load)
        begin
            func_next     = in_func;
            n_zero_next   = (n_full == '0);
            nofit_next    = (n_full > N_W'(PAGE_COUNT)) ||
                            (CW'(reserved_reg) >= CW'(PAGE_COUNT));
            free_bad_next = end_sum > EW'(PAGE_COUNT);
            n_next        = RW'(n_full);
            lo_page_next  = PW'(sp_full);
            hi_page_next  = PW'(end_sum - EW'(1));
        end

        if (cmd.scan_init)
        begin
            scan_addr_next = AW'(reserved_reg >> IW);
            scan_more_next = 1'b1;
            eval_vld_next  = 1'b0;
            found_next     = 1'b0;
            carry_next     = '0;
        end

        if (cmd.scan_step)
        begin
            eval_vld_next = issue;
            if (issue)
            begin
                eval_addr_next = scan_addr_reg;
                scan_addr_next = scan_addr_reg + AW'(1);
                if (scan_addr_reg == LAST_ROW)
                begin
                    scan_more_next = 1'b0;
                end
            end
            if (hit_now)
            begin
                found_next   = 1'b1;
                lo_page_next = start_page;
                hi_page_next = end_page;
            end
            else if (eval_vld_reg)
            begin
                carry_next = run_v[WORD_W-1][RW-1:0];
            end
        end

        if (cmd.walk_init)
        begin
            walk_addr_next = lo_row;
            if (!func_reg)
            begin
                if (CW'(count_reg) >= CW'(n_reg))
                begin
                    count_next = count_reg - CNT_W'(n_reg);
                end
                else
                begin
                    count_next = '0;
                end
            end
        end

        if (cmd.mark_wr)
        begin
            walk_addr_next = walk_addr_reg + AW'(1);
        end

        if (cmd.free_wr)
        begin
            walk_addr_next = walk_addr_reg + AW'(1);
            count_next     = (cnt_sum > (CNT_W+1)'(CNT_MAX)) ? CNT_MAX : cnt_sum[CNT_W-1:0];
        end

        if (cmd.finish)
        begin
            out_vld_next    = 1'b1;
            out_status_next = cmd.res_status;
            out_free_next   = count_reg;
            if ((cmd.res_status == ST_OK) && !func_reg)
            begin
                out_addr_next = OUT_ADDR_W'({lo_page_reg, {PAGE_SHIFT{1'b0}}});
            end
            else
            begin
                out_addr_next = '0;
            end
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg  <= RESERVED_RST;
            init_free_reg <= INIT_FREE_RST;
            count_reg     <= INIT_FREE_RST;
            row_reg       <= '0;
            scan_more_reg <= 1'b0;
            eval_vld_reg  <= 1'b0;
            found_reg     <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            reserved_reg  <= reserved_next;
            init_free_reg <= init_free_next;
            count_reg     <= count_next;
            row_reg       <= row_next;
            scan_more_reg <= scan_more_next;
            eval_vld_reg  <= eval_vld_next;
            found_reg     <= found_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        n_zero_reg     <= n_zero_next;
        nofit_reg      <= nofit_next;
        free_bad_reg   <= free_bad_next;
        n_reg          <= n_next;
        lo_page_reg    <= lo_page_next;
        hi_page_reg    <= hi_page_next;
        scan_addr_reg  <= scan_addr_next;
        eval_addr_reg  <= eval_addr_next;
        carry_reg      <= carry_next;
        walk_addr_reg  <= walk_addr_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_free_reg   <= out_free_next;
    end

    assign st.row_last    = (row_reg == LAST_ROW);
    assign st.func_free   = func_reg;
    assign st.n_zero      = n_zero_reg;
    assign st.alloc_nofit = nofit_reg;
    assign st.free_bad    = free_bad_reg;
    assign st.scan_found  = found_reg;
    assign st.scan_done   = !scan_more_reg && !eval_vld_reg && !found_reg;
    assign st.walk_last   = (walk_addr_reg == hi_row);
    assign st.free_err    = |miss;
    assign st.out_free    = !out_vld_reg || out_ready;

    assign out_valid  = out_vld_reg;
    assign out_status = out_status_reg;
    assign out_addr   = out_addr_reg;
    assign out_free   = out_free_reg;

endmodule

// ===== rtl/bpa_checker.sv =====
// Port-level checks of the page allocator and their attachment to the top level.
module bpa_checker
    import bpa_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK) |-> m_axis_tdata[24:2] == '0)
        else $error("failed request carries a nonzero address");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while another is in progress");

    a_cfg_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready &&
        ((cfg_index == CFG_RESERVED) || (cfg_index == CFG_INIT_FREE)) |=> !s_axis_tready)
        else $error("request taken during map rebuild");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index)
);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the first-fit bitmap page allocator.
`timescale 1ns / 1ps

module tb;
    import bpa_pkg::*;

    localparam int PAGES = PAGE_COUNT_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_REQUESTS = 105;
    localparam int TAIL_CYCLES = 300;

    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [OUT_ADDR_W-1:0] addr;
        logic [CNT_W-1:0]      free_pg;
    } alloc_result_t;

    typedef struct {
        logic          fn;
        logic [31:0]   sz;
        logic [31:0]   ba;
        bit            typed;
        alloc_result_t want;
    } stim_row_t;

    typedef struct {
        int unsigned first;
        int unsigned cnt;
    } page_run_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Mirror of the allocator state.
    bit   [PAGES-1:0] page_used;
    logic [CNT_W-1:0] free_count;
    logic [CNT_W-1:0] boundary_cfg;
    logic [CNT_W-1:0] init_free_cfg;

    alloc_result_t pending_results[$];
    page_run_t     live_runs[$];
    int            mismatch_count = 0;
    int            cycle_count = 0;
    int            burst_left = 0;
    int            stall_mode = 0;
    int            stall_timer = 0;

    stim_row_t     directed_rows[21];
    logic [CNT_W-1:0] phase_boundary[8] = '{12'd512, 12'd0, 12'd2047, 12'd4095,
                                           12'd0, 12'd100, 12'd2048, 12'd1024};
    logic [CNT_W-1:0] phase_free[8] = '{12'd1536, 12'd2048, 12'd1, 12'd4095,
                                       12'd0, 12'd4090, 12'd2048, 12'd1024};

    bitmap_page_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic void rebuild_map();
        page_used = '0;
        for (int pg = 0; pg < PAGES && pg < boundary_cfg; pg++)
            page_used[pg] = 1'b1;
        free_count = init_free_cfg;
        live_runs.delete();
    endfunction

    function automatic alloc_result_t apply_request(input logic fn, input logic [31:0] sz,
                                                    input logic [31:0] ba);
        alloc_result_t    r;
        logic [32:0]      n_pages;
        int unsigned      run_len;
        int unsigned      pg;
        int unsigned      first_pg;
        longint unsigned  start_pg;
        longint unsigned  end_pg;
        bit               found;
        r.status = ST_OK;
        r.addr = '0;
        n_pages = ({1'b0, sz} + 33'hfff) >> PAGE_SHIFT;
        if (fn == FN_ALLOC)
        begin
            if (n_pages == 0)
                r.status = ST_BAD;
            else
            begin
                run_len = 0;
                found = 1'b0;
                first_pg = 0;
                for (pg = 32'(boundary_cfg); pg < PAGES; pg++)
                begin
                    if (page_used[pg])
                        run_len = 0;
                    else
                        run_len++;
                    if (run_len == n_pages)
                    begin
                        found = 1'b1;
                        first_pg = pg + 1 - run_len;
                        break;
                    end
                end
                if (!found)
                    r.status = ST_NOSPACE;
                else
                begin
                    for (pg = first_pg; pg < first_pg + run_len; pg++)
                        page_used[pg] = 1'b1;
                    if (n_pages > free_count)
                        free_count = '0;
                    else
                        free_count = free_count - CNT_W'(n_pages);
                    r.addr = OUT_ADDR_W'(first_pg << PAGE_SHIFT);
                    live_runs.push_back('{first_pg, run_len});
                end
            end
        end
        else
        begin
            start_pg = 64'(ba >> PAGE_SHIFT);
            end_pg = start_pg + 64'(n_pages);
            if (end_pg > PAGES)
                r.status = ST_BAD;
            else
            begin
                for (longint unsigned k = start_pg; k < end_pg; k++)
                begin
                    // Pages cleared before the first unused one stay free.
                    if (!page_used[k])
                    begin
                        r.status = ST_NOTUSED;
                        break;
                    end
                    page_used[k] = 1'b0;
                    if (free_count != CNT_MAX)
                        free_count = free_count + CNT_W'(1);
                end
            end
        end
        r.free_pg = free_count;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input alloc_result_t want,
                                   input alloc_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t: %s: expected status %0d addr 0x%06h free %0d",
                     $realtime, what, want.status, want.addr, want.free_pg);
            $display("    got status %0d addr 0x%06h free %0d",
                     got.status, got.addr, got.free_pg);
        end
    endtask

    task automatic send_request(input logic fn, input logic [31:0] sz, input logic [31:0] ba,
                                input bit typed, input alloc_result_t typed_want);
        alloc_result_t predicted;
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {ba, sz};
        do @(posedge clk); while (!s_axis_tready);
        burst_left--;
        predicted = apply_request(fn, sz, ba);
        pending_results.push_back(typed ? typed_want : predicted);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_config(input logic [CNT_W-1:0] boundary,
                               input logic [CNT_W-1:0] start_free);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_RESERVED;
        cfg_data  <= boundary;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_INIT_FREE;
        cfg_data  <= start_free;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        boundary_cfg = boundary;
        init_free_cfg = start_free;
        rebuild_map();
    endtask

    // Mostly allocations and frees of runs handed out earlier, plus stray and random requests.
    task automatic next_request(output logic fn, output logic [31:0] sz, output logic [31:0] ba);
        int unsigned pick;
        int unsigned alloc_cut;
        int unsigned idx;
        int unsigned k;
        int unsigned n;
        page_run_t   r;
        pick = $urandom_range(0, 99);
        alloc_cut = (live_runs.size() > 40) ? 30 : 55;
        fn = FN_ALLOC;
        ba = $urandom();
        if (pick >= 93)
        begin
            fn = 1'($urandom_range(0, 1));
            sz = $urandom();
        end
        else if (pick >= 85)
        begin
            fn = FN_FREE;
            n = $urandom_range(1, 4);
            ba = ($urandom_range(0, PAGES - 1) << PAGE_SHIFT) | $urandom_range(0, 4095);
            sz = (n << PAGE_SHIFT) - $urandom_range(0, 4095);
        end
        else if (pick >= alloc_cut && live_runs.size() != 0)
        begin
            idx = $urandom_range(0, live_runs.size() - 1);
            r = live_runs[idx];
            k = ($urandom_range(0, 3) == 0) ? $urandom_range(1, r.cnt) : r.cnt;
            fn = FN_FREE;
            ba = (r.first << PAGE_SHIFT) | $urandom_range(0, 4095);
            sz = (k << PAGE_SHIFT) - $urandom_range(0, 4095);
            if (k == r.cnt)
                live_runs.delete(idx);
            else
            begin
                live_runs[idx].first = r.first + k;
                live_runs[idx].cnt = r.cnt - k;
            end
        end
        else
        begin
            k = $urandom_range(0, 99);
            if (k < 3)
                sz = 32'd0;
            else if (k < 7)
                sz = $urandom();
            else if (k < 15)
                sz = $urandom_range(17, PAGES) << PAGE_SHIFT;
            else
            begin
                n = $urandom_range(1, 16);
                sz = ((n - 1) << PAGE_SHIFT) + $urandom_range(1, 4096);
            end
        end
    endtask

    // The receiver switches between always ready, random stalls and a fixed duty pattern.
    always @(posedge clk)
    begin
        if (stall_timer == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_timer <= $urandom_range(16, 96);
        end
        else
            stall_timer <= stall_timer - 1;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= (cycle_count % 8) >= 3;
        endcase
    end

    always @(posedge clk)
    begin
        alloc_result_t got;
        alloc_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status  = m_axis_tdata[1:0];
            got.addr    = m_axis_tdata[24:2];
            got.free_pg = m_axis_tdata[36:25];
            if (pending_results.size() == 0)
                report_mismatch("result with none pending", '0, got);
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.addr !== want.addr
                    || got.free_pg !== want.free_pg)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        logic        fn;
        logic [31:0] sz;
        logic [31:0] ba;

        // Rows typed in as expected results follow directly from the reset map.
        directed_rows = '{
            '{FN_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_BAD,     23'h000000, 12'd1536}},
            '{FN_ALLOC, 32'h0000_0001, 32'h0000_0000, 1'b1, '{ST_OK,      23'h200000, 12'd1535}},
            '{FN_ALLOC, 32'h0000_1000, 32'hFFFF_FFFF, 1'b1, '{ST_OK,      23'h201000, 12'd1534}},
            '{FN_ALLOC, 32'h0000_1001, 32'h0000_0000, 1'b1, '{ST_OK,      23'h202000, 12'd1532}},
            '{FN_ALLOC, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{ST_NOSPACE, 23'h000000, 12'd1532}},
            '{FN_FREE,  32'h0000_1000, 32'h0020_1FFF, 1'b1, '{ST_OK,      23'h000000, 12'd1533}},
            '{FN_ALLOC, 32'h0000_1000, 32'h0000_0000, 1'b0, '0},
            '{FN_FREE,  32'h0000_3000, 32'h0020_1000, 1'b0, '0},
            '{FN_FREE,  32'h0000_3000, 32'h0020_1000, 1'b0, '0},
            '{FN_FREE,  32'h0000_4000, 32'h0020_0000, 1'b0, '0},
            '{FN_FREE,  32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_OK,      23'h000000, 12'd1536}},
            '{FN_FREE,  32'h0000_2000, 32'h007F_F000, 1'b1, '{ST_BAD,     23'h000000, 12'd1536}},
            '{FN_FREE,  32'h0000_0001, 32'hFFFF_FFFF, 1'b1, '{ST_BAD,     23'h000000, 12'd1536}},
            '{FN_FREE,  32'h0000_1000, 32'h007F_F000, 1'b1, '{ST_NOTUSED, 23'h000000, 12'd1536}},
            '{FN_FREE,  32'h0000_1000, 32'h0000_0000, 1'b0, '0},
            '{FN_ALLOC, 32'h0000_0001, 32'h0000_0000, 1'b0, '0},
            '{FN_ALLOC, 32'h0060_0000, 32'h0000_0000, 1'b0, '0},
            '{FN_ALLOC, 32'h005F_F000, 32'h0000_0000, 1'b0, '0},
            '{FN_ALLOC, 32'h0000_0001, 32'h0000_0000, 1'b0, '0},
            '{FN_FREE,  32'h0060_0000, 32'h0020_0000, 1'b0, '0},
            '{FN_FREE,  32'h0080_0000, 32'h0000_0000, 1'b0, '0}
        };

        boundary_cfg = RESERVED_RST;
        init_free_cfg = INIT_FREE_RST;
        rebuild_map();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].fn, directed_rows[i].sz, directed_rows[i].ba,
                         directed_rows[i].typed, directed_rows[i].want);
        wait_idle();

        foreach (phase_boundary[p])
        begin
            load_config(phase_boundary[p], phase_free[p]);
            repeat (PHASE_REQUESTS)
            begin
                next_request(fn, sz, ba);
                send_request(fn, sz, ba, 1'b0, '0);
            end
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        mismatch_count += pending_results.size();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== bitmap_page_allocator.f =====
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/bpa_ctrl.sv
rtl/bpa_dp.sv
rtl/bitmap_page_allocator.sv
rtl/bpa_checker.sv
tb/sv/tb.sv
